// ----- hw/rtl/lst_pkg.sv -----
// Package: shared constants, command codes, state and control types.
`default_nettype none
package lst_pkg;
  localparam int unsigned BucketCountDefault    = 1024;
  localparam int unsigned SlotsPerBucketDefault = 32;
  localparam int unsigned HashShift             = 5;
  localparam int unsigned AddrW                 = 32;
  localparam int unsigned CountW                = 32;
  localparam int unsigned DepthW                = 16;

  typedef enum logic [1:0] {
    CMD_LOCK   = 2'd0,
    CMD_TRY    = 2'd1,
    CMD_UNLOCK = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_PROBE,
    ST_READ,
    ST_WAIT,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic wipe_start;
    logic wipe_step;
    logic probe_start;
    logic probe_step;
    logic entry_read;
    logic entry_write;
    logic out_load;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic wipe_done;
    logic probe_done;
    logic is_clear;
  } stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/lst_datapath.sv -----
// Datapath: slot memories, probe counter, entry update and result register.
`default_nettype none
module lst_datapath import lst_pkg::*; #(
  parameter int unsigned BUCKET_COUNT     = BucketCountDefault,
  parameter int unsigned SLOTS_PER_BUCKET = SlotsPerBucketDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_t             ctrl_i,
  output stat_t                  stat_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [AddrW-1:0]  lock_address_i,
  input  wire logic [AddrW-1:0]  caller_address_i,
  input  wire logic              got_lock_first_try_i,
  input  wire logic              interrupts_masked_i,
  input  wire logic              thread_present_i,
  input  wire logic [DepthW-1:0] thread_lock_depth_i,
  input  wire logic [AddrW-1:0]  now_stamp_i,
  output logic                   acquired_o,
  output logic                   used_overflow_entry_o,
  output logic [DepthW-1:0]      thread_lock_depth_out_o,
  output logic [CountW-1:0]      entry_success_count_o,
  output logic [CountW-1:0]      entry_fail_count_o
);
  localparam int unsigned Total = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int unsigned IdxW  = (Total > 1) ? $clog2(Total) : 1;
  localparam int unsigned BktW  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned WipeW = $clog2(Total + 1);
  localparam logic [31:0] BktMask = 32'(BUCKET_COUNT - 1);

  // Captured item
  logic [1:0]        cmd_q;
  logic [AddrW-1:0]  addr_q, caller_q, now_q;
  logic              got_q, msk_q, thr_q;
  logic [DepthW-1:0] depth_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= cmd_i;
      addr_q   <= lock_address_i;
      caller_q <= caller_address_i;
      got_q    <= got_lock_first_try_i;
      msk_q    <= interrupts_masked_i;
      thr_q    <= thread_present_i;
      depth_q  <= thread_lock_depth_i;
      now_q    <= now_stamp_i;
    end
  end

  // Slot memories; tag and caller form one word, the counters another
  localparam int unsigned RecW = 4*CountW + DepthW;
  logic [2*AddrW-1:0] tag_mem [Total];
  logic [RecW-1:0]    rec_mem [Total];

  logic [WipeW-1:0] wipe_q;
  logic             wipe_act_q;
  logic [CntW-1:0]  probe_q;
  logic             probe_act_q, probe_done_q, ovf_q;
  logic [IdxW-1:0]  slot_q;
  logic [2*AddrW-1:0] tag_rd_q;
  logic [RecW-1:0]  rec_rd_q;
  logic             rd_vld_q;
  logic [RecW-1:0]  ovf_rec_q;
  logic [IdxW-1:0]  rd_idx;
  logic [BktW-1:0]  bucket;
  logic [31:0]      bkt_full;

  assign bkt_full = (addr_q >> HashShift) & BktMask;
  assign bucket   = bkt_full[BktW-1:0];
  assign rd_idx   = IdxW'(bucket) * IdxW'(SLOTS_PER_BUCKET) + IdxW'(probe_q);

  // Probe: one tag read per cycle, registered, checked next cycle
  logic [AddrW-1:0] rd_tag;
  logic             hit, empty_hit;
  assign rd_tag    = tag_rd_q[2*AddrW-1:AddrW];
  assign empty_hit = rd_tag == '0;
  assign hit       = rd_vld_q && (empty_hit || rd_tag == addr_q);

  logic [IdxW-1:0] rd_idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q      <= '0;
      probe_act_q  <= 1'b0;
      probe_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      ovf_q        <= 1'b0;
      slot_q       <= '0;
    end else if (ctrl_i.probe_start) begin
      probe_q      <= '0;
      probe_act_q  <= 1'b1;
      probe_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      ovf_q        <= 1'b0;
    end else if (ctrl_i.probe_step && probe_act_q) begin
      if (hit) begin
        probe_act_q  <= 1'b0;
        probe_done_q <= 1'b1;
        slot_q       <= rd_idx_q;
        rd_vld_q     <= 1'b0;
      end else if (rd_vld_q && probe_q == CntW'(SLOTS_PER_BUCKET)) begin
        probe_act_q  <= 1'b0;
        probe_done_q <= 1'b1;
        ovf_q        <= 1'b1;
        rd_vld_q     <= 1'b0;
      end else if (probe_q != CntW'(SLOTS_PER_BUCKET)) begin
        probe_q  <= probe_q + 1'b1;
        rd_vld_q <= 1'b1;
      end
    end
  end

  // Tag memory port
  logic [IdxW-1:0] rec_idx;
  assign rec_idx = ctrl_i.entry_read ? slot_q : slot_q;
  always_ff @(posedge clk_i) begin
    if (wipe_act_q) begin
      tag_mem[wipe_q[IdxW-1:0]] <= '0;
    end else if (ctrl_i.probe_step && probe_act_q && hit && empty_hit) begin
      tag_mem[rd_idx_q] <= {addr_q, caller_q};
    end
    if (probe_act_q && probe_q != CntW'(SLOTS_PER_BUCKET)) begin
      tag_rd_q <= tag_mem[rd_idx];
      rd_idx_q <= rd_idx;
    end
  end

  // Counter record: new value computed from the registered read, or from the overflow entry when the bucket is full
  logic [RecW-1:0] cur, nxt;
  logic [CountW-1:0] c_suc, c_fail, c_msk, c_time, n_suc, n_fail, n_msk, n_time;
  logic [DepthW-1:0] c_held, n_held, n_depth;
  logic              n_acq;
  assign cur = ovf_q ? ovf_rec_q : rec_rd_q;
  assign {c_suc, c_fail, c_msk, c_held, c_time} = cur;

  always_comb begin
    n_suc   = c_suc;
    n_fail  = c_fail;
    n_msk   = c_msk;
    n_held  = c_held;
    n_time  = c_time;
    n_depth = depth_q;
    n_acq   = 1'b0;
    unique case (cmd_e'(cmd_q))
      CMD_LOCK: begin
        if (thr_q) begin
          n_held  = depth_q;
          n_depth = (depth_q == '1) ? depth_q : depth_q + 1'b1;
        end
        if (msk_q) n_msk = c_msk + 1'b1;
        if (got_q) n_suc = c_suc + 1'b1;
        else n_fail = c_fail + 1'b1;
        n_time = now_q - c_time;
        n_acq  = 1'b1;
      end
      CMD_TRY: begin
        if (msk_q) n_msk = c_msk + 1'b1;
        if (got_q) begin
          n_suc  = c_suc + 1'b1;
          n_time = now_q - c_time;
          if (thr_q) begin
            n_held  = depth_q;
            n_depth = (depth_q == '1) ? depth_q : depth_q + 1'b1;
          end
          n_acq = 1'b1;
        end else begin
          n_fail = c_fail + 1'b1;
        end
      end
      CMD_UNLOCK: begin
        n_time = now_q - c_time;
        if (thr_q && depth_q != '0) n_depth = depth_q - 1'b1;
      end
      default: begin
        n_suc  = '0;
        n_fail = '0;
      end
    endcase
  end
  assign nxt = {n_suc, n_fail, n_msk, n_held, n_time};

  always_ff @(posedge clk_i) begin
    if (wipe_act_q) begin
      rec_mem[wipe_q[IdxW-1:0]] <= '0;
    end else if (ctrl_i.entry_write && !ovf_q) begin
      rec_mem[rec_idx] <= nxt;
    end
    if (ctrl_i.entry_read) rec_rd_q <= rec_mem[rec_idx];
  end

  // Overflow entry and wipe sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_rec_q  <= '0;
      wipe_q     <= '0;
      wipe_act_q <= 1'b0;
    end else begin
      if (ctrl_i.wipe_start) begin
        wipe_q     <= '0;
        wipe_act_q <= 1'b1;
        ovf_rec_q  <= '0;
      end else if (wipe_act_q) begin
        if (wipe_q == WipeW'(Total - 1)) wipe_act_q <= 1'b0;
        wipe_q <= wipe_q + 1'b1;
      end
      if (ctrl_i.entry_write && ovf_q) ovf_rec_q <= nxt;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      if (cmd_e'(cmd_q) == CMD_CLEAR) begin
        acquired_o              <= 1'b0;
        used_overflow_entry_o   <= 1'b0;
        thread_lock_depth_out_o <= depth_q;
        entry_success_count_o   <= '0;
        entry_fail_count_o      <= '0;
      end else begin
        acquired_o              <= n_acq;
        used_overflow_entry_o   <= ovf_q;
        thread_lock_depth_out_o <= n_depth;
        entry_success_count_o   <= n_suc;
        entry_fail_count_o      <= n_fail;
      end
    end
  end

  assign stat_o.wipe_done  = !wipe_act_q;
  assign stat_o.probe_done = probe_done_q;
  assign stat_o.is_clear   = cmd_e'(cmd_q) == CMD_CLEAR;
  logic unused;
  assign unused = ctrl_i.wipe_step ^ (|bkt_full);
endmodule
`default_nettype wire

// ----- hw/rtl/lst_ctrl.sv -----
// Controller: sequences wipe, probe, read-modify-write and result hand-off.
`default_nettype none
module lst_ctrl import lst_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output ctrl_t      ctrl_o,
  input  wire stat_t stat_i,
  output state_e     state_o
);
  state_e state_q, state_d;
  logic   started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_WIPE;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= state_q == ST_WIPE;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_WIPE:   if (started_q && stat_i.wipe_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_PROBE;
      ST_PROBE:  if (stat_i.is_clear) state_d = ST_OUT;
                 else if (stat_i.probe_done) state_d = ST_READ;
      ST_READ:   state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = stat_i.is_clear ? ST_WIPE : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_WIPE:   ctrl_o.wipe_start = !started_q;
      ST_IDLE: begin
        in_ready_o         = 1'b1;
        ctrl_o.capture     = in_valid_i;
        ctrl_o.probe_start = in_valid_i;
      end
      ST_PROBE: begin
        ctrl_o.probe_step = 1'b1;
        ctrl_o.out_load   = stat_i.is_clear;
      end
      ST_READ:   ctrl_o.entry_read = 1'b1;
      ST_WAIT:   ctrl_o.wipe_step = 1'b0;
      ST_UPDATE: begin
        ctrl_o.entry_write = 1'b1;
        ctrl_o.out_load    = 1'b1;
      end
      ST_OUT:    out_valid_o = 1'b1;
      default:   ctrl_o = '0;
    endcase
  end
  assign state_o = state_q;
endmodule
`default_nettype wire

// ----- hw/rtl/lock_statistics_table_top.sv -----
// Lock statistics table: one event in, one result beat out, sequential. The
// bucket is probed one slot per cycle through the registered tag memory read,
// then the entry is read, updated and written. The probe ends when a slot
// matches or is claimed, or when the bucket is full. Each event passes
// through the idle, probe, read, wait, update and output states before the
// next one is accepted, and the receiver may hold off the result. A clear
// goes from probe straight to output and then, as after reset, a sweep over
// all BUCKET_COUNT*SLOTS_PER_BUCKET slots zeroes the memories; no event is
// accepted meanwhile. The result beat stays on the port until taken.
`default_nettype none
module lock_statistics_table_top import lst_pkg::*; #(
  parameter int unsigned BUCKET_COUNT     = BucketCountDefault,
  parameter int unsigned SLOTS_PER_BUCKET = SlotsPerBucketDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [AddrW-1:0]  lock_address_i,
  input  wire logic [AddrW-1:0]  caller_address_i,
  input  wire logic              got_lock_first_try_i,
  input  wire logic              interrupts_masked_i,
  input  wire logic              thread_present_i,
  input  wire logic [DepthW-1:0] thread_lock_depth_i,
  input  wire logic [AddrW-1:0]  now_stamp_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   acquired_o,
  output logic                   used_overflow_entry_o,
  output logic [DepthW-1:0]      thread_lock_depth_out_o,
  output logic [CountW-1:0]      entry_success_count_o,
  output logic [CountW-1:0]      entry_fail_count_o
);
  ctrl_t  ctrl;
  stat_t  stat;
  state_e state;

  lst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .ctrl_o(ctrl), .stat_i(stat), .state_o(state)
  );

  lst_datapath #(
    .BUCKET_COUNT(BUCKET_COUNT), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i, .lock_address_i, .caller_address_i, .got_lock_first_try_i,
    .interrupts_masked_i, .thread_present_i, .thread_lock_depth_i, .now_stamp_i,
    .acquired_o, .used_overflow_entry_o, .thread_lock_depth_out_o,
    .entry_success_count_o, .entry_fail_count_o
  );

  // Never take an event while a result beat is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  // A result beat only follows from the output state
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state == ST_OUT) else $error("valid outside output state");
  // Accepted event leaves idle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");
endmodule
`default_nettype wire
